@@ rtl/amgt_pkg.sv @@
// ----------------------------------------------------------------------------
// amgt_pkg
// Shared widths, action codes and the emit request type of the adjacency
// matrix graph traversal unit.
// ----------------------------------------------------------------------------
package amgt_pkg;

    // Fixed field widths
    localparam int unsigned VTX_W = 6;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned ACT_W = 2;

    // Defaults
    localparam int unsigned MAX_VERTICES_DEF = 64;
    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

    // Item actions
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_EDGE   = 2'd0,
        ACT_DEL_VERTEX = 2'd1,
        ACT_DFS        = 2'd2,
        ACT_BFS        = 2'd3
    } t_action;

    // Request from the sequencer to the result stage
    typedef struct packed {
        logic             push;   // new vertex found
        logic             flush;  // traversal done, release held vertex as last
        logic [VTX_W-1:0] vtx;
    } t_emit_req;

endpackage

@@ rtl/amgt_ffs.sv @@
// ----------------------------------------------------------------------------
// amgt_ffs
// Find the lowest set bit of a candidate vector.
// ----------------------------------------------------------------------------
module amgt_ffs #(
    parameter int unsigned WIDTH = amgt_pkg::MAX_VERTICES_DEF
) (
    input  logic [WIDTH-1:0]         i_vec,
    output logic                     o_found,
    output logic [$clog2(WIDTH)-1:0] o_idx
);

    localparam int unsigned IDX_W = $clog2(WIDTH);

    // Scan from the top so the lowest set bit wins
    always_comb begin
        o_idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

    assign o_found = |i_vec;

endmodule

@@ rtl/amgt_emit.sv @@
// ----------------------------------------------------------------------------
// amgt_emit
// Result stage: hold the most recent vertex until the next one is found or
// the traversal ends, so that the final vertex can carry the last flag.
// ----------------------------------------------------------------------------
module amgt_emit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  amgt_pkg::t_emit_req              i_req,
    output logic                             o_ready,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [amgt_pkg::VTX_W-1:0]       o_vertex,
    output logic                             o_last
);

    logic                       r_pend_v;
    logic [amgt_pkg::VTX_W-1:0] r_pend_vtx;
    logic                       r_out_v;
    logic [amgt_pkg::VTX_W-1:0] r_out_vtx;
    logic                       r_out_last;
    logic                       w_load;

    // Output slot is free when empty or being taken this cycle
    assign o_ready = !r_out_v || i_out_ready;
    assign w_load  = (i_req.push && r_pend_v) || i_req.flush;

    // Track held vertex and output occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_req.push) begin
                r_pend_v <= 1'b1;
            end else if (i_req.flush) begin
                r_pend_v <= 1'b0;
            end
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Move held vertex to the output, capture the new one
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_vtx  <= r_pend_vtx;
            r_out_last <= i_req.flush;
        end
        if (i_req.push) begin
            r_pend_vtx <= i_req.vtx;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_vertex    = r_out_vtx;
    assign o_last      = r_out_last;

endmodule

@@ rtl/adjacency_matrix_graph_traversal_unit.sv @@
// Add edge: read row a, then write row a and read row b, then write row b.
// Delete vertex: rows below the effective vertex count, one read-modify-write per cycle.
// Depth-first: row read, scan and pop per vertex reached.
// Breadth-first: dequeue, queue read and scan; one vertex found per cycle unless stalled.
// A new request is taken only from idle; results leave through a one-entry
// output register. Reset clears per-row valid bits, so the matrix reads empty.
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_traversal_unit
// Bit adjacency matrix of an undirected graph with edge insertion, vertex
// deletion, and depth-first / breadth-first traversal.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_traversal_unit #(
    parameter int unsigned MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [amgt_pkg::CNT_W-1:0]   i_cfg_wdata,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [amgt_pkg::ACT_W-1:0]   i_action,
    input  logic [amgt_pkg::VTX_W-1:0]   i_vertex_a,
    input  logic [amgt_pkg::VTX_W-1:0]   i_vertex_b,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [amgt_pkg::VTX_W-1:0]   o_vertex,
    output logic                         o_last
);

    localparam int unsigned VW = $clog2(MAX_VERTICES);
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned EW = (CW > amgt_pkg::CNT_W) ? CW : amgt_pkg::CNT_W;
    localparam logic [MAX_VERTICES-1:0] ONE_BIT = MAX_VERTICES'(1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_ADD_A    = 9'b000000010,
        ST_ADD_B    = 9'b000000100,
        ST_DEL      = 9'b000001000,
        ST_DFS_EVAL = 9'b000010000,
        ST_DFS_POP  = 9'b000100000,
        ST_BFS_DEQ  = 9'b001000000,
        ST_BFS_QRD  = 9'b010000000,
        ST_BFS_SCAN = 9'b100000000
    } t_state;

    t_state                   r_state, n_state;
    logic [amgt_pkg::CNT_W-1:0] r_vertex_count;
    logic [VW-1:0]            r_a, n_a;
    logic [VW-1:0]            r_b, n_b;
    logic [EW-1:0]            r_n, n_n;
    logic [MAX_VERTICES-1:0]  r_nmask, n_nmask;
    logic [MAX_VERTICES-1:0]  r_visited, n_visited;
    logic [CW-1:0]            r_depth, n_depth;
    logic [CW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_tail, n_tail;
    logic [CW-1:0]            r_idx, n_idx;
    logic [VW-1:0]            r_widx, n_widx;
    logic                     r_wpend, n_wpend;

    // adjacency memory
    logic [MAX_VERTICES-1:0]  r_adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  r_row_vld;
    logic [MAX_VERTICES-1:0]  r_row_q;
    logic                     w_adj_re, w_adj_we;
    logic [VW-1:0]            w_adj_raddr, w_adj_waddr;
    logic [MAX_VERTICES-1:0]  w_adj_wdata;

    // stack / queue memory, shared since one traversal runs at a time
    logic [VW-1:0]            r_lst_mem [MAX_VERTICES];
    logic [VW-1:0]            r_lst_q;
    logic                     w_lst_re, w_lst_we;
    logic [VW-1:0]            w_lst_raddr, w_lst_waddr, w_lst_wdata;

    // request decode
    logic [EW-1:0]            w_cnt_ext, w_n_eff, w_a_ext, w_b_ext;
    logic [VW-1:0]            w_a_idx, w_b_idx;
    logic                     w_a_ok, w_b_ok, w_start;
    logic [MAX_VERTICES-1:0]  w_nmask_calc;

    // neighbor search
    logic [MAX_VERTICES-1:0]  w_cand;
    logic                     w_found;
    logic [VW-1:0]            w_ffs_idx;
    logic [CW-1:0]            w_pop_pos;
    logic [CW-1:0]            w_idx_m;

    // result stage
    amgt_pkg::t_emit_req      s_emit;
    logic                     w_emit_rdy;
    logic [VW-1:0]            w_push_idx;
    logic [EW-1:0]            w_push_ext;

    // Clamp the vertex count and widen the vertex fields
    assign w_cnt_ext = EW'(r_vertex_count);
    assign w_n_eff   = (w_cnt_ext > EW'(MAX_VERTICES)) ? EW'(MAX_VERTICES) : w_cnt_ext;
    assign w_a_ext   = EW'(i_vertex_a);
    assign w_b_ext   = EW'(i_vertex_b);
    assign w_a_idx   = w_a_ext[VW-1:0];
    assign w_b_idx   = w_b_ext[VW-1:0];
    assign w_a_ok    = w_a_ext < w_n_eff;
    assign w_b_ok    = w_b_ext < w_n_eff;
    assign w_start   = o_in_ready && i_in_valid && w_a_ok &&
                       ((i_action == amgt_pkg::ACT_DFS) || (i_action == amgt_pkg::ACT_BFS));

    // Mask of vertex indices in use
    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            w_nmask_calc[j] = EW'(j) < w_n_eff;
        end
    end

    // Unvisited neighbors of the row just read
    assign w_cand = r_row_q & ~r_visited & r_nmask;

    amgt_ffs #(
        .WIDTH (MAX_VERTICES)
    ) u_ffs (
        .i_vec   (w_cand),
        .o_found (w_found),
        .o_idx   (w_ffs_idx)
    );

    assign w_pop_pos  = r_depth - CW'(2);
    assign w_idx_m    = r_idx;
    assign o_in_ready = (r_state == ST_IDLE);

    // Vertex sent to the result stage
    assign w_push_idx = (r_state == ST_IDLE) ? w_a_idx : w_ffs_idx;
    assign w_push_ext = EW'(w_push_idx);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_n         = r_n;
        n_nmask     = r_nmask;
        n_visited   = r_visited;
        n_depth     = r_depth;
        n_head      = r_head;
        n_tail      = r_tail;
        n_idx       = r_idx;
        n_widx      = r_widx;
        n_wpend     = r_wpend;
        s_emit      = '0;
        s_emit.vtx  = w_push_ext[amgt_pkg::VTX_W-1:0];
        w_adj_re    = 1'b0;
        w_adj_raddr = '0;
        w_adj_we    = 1'b0;
        w_adj_waddr = '0;
        w_adj_wdata = '0;
        w_lst_re    = 1'b0;
        w_lst_raddr = '0;
        w_lst_we    = 1'b0;
        w_lst_waddr = '0;
        w_lst_wdata = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_a     = w_a_idx;
                    n_b     = w_b_idx;
                    n_n     = w_n_eff;
                    n_nmask = w_nmask_calc;
                    if (w_a_ok) begin
                        unique case (amgt_pkg::t_action'(i_action))
                            amgt_pkg::ACT_ADD_EDGE: begin
                                if (w_b_ok) begin
                                    w_adj_re    = 1'b1;
                                    w_adj_raddr = w_a_idx;
                                    n_state     = ST_ADD_A;
                                end
                            end
                            amgt_pkg::ACT_DEL_VERTEX: begin
                                n_idx   = '0;
                                n_wpend = 1'b0;
                                n_state = ST_DEL;
                            end
                            amgt_pkg::ACT_DFS, amgt_pkg::ACT_BFS: begin
                                // result stage holds nothing while idle
                                s_emit.push = 1'b1;
                                n_visited   = ONE_BIT << w_a_idx;
                                w_lst_we    = 1'b1;
                                w_lst_waddr = '0;
                                w_lst_wdata = w_a_idx;
                                n_depth     = CW'(1);
                                n_head      = '0;
                                n_tail      = CW'(1);
                                if (i_action == amgt_pkg::ACT_DFS) begin
                                    w_adj_re    = 1'b1;
                                    w_adj_raddr = w_a_idx;
                                    n_state     = ST_DFS_EVAL;
                                end else begin
                                    n_state = ST_BFS_DEQ;
                                end
                            end
                        endcase
                    end
                end
            end

            // Row a is in hand: set bit b, fetch row b
            ST_ADD_A: begin
                w_adj_we    = 1'b1;
                w_adj_waddr = r_a;
                w_adj_wdata = r_row_q | (ONE_BIT << r_b);
                // a self edge reads the old row here; both writes set the same bit
                w_adj_re    = 1'b1;
                w_adj_raddr = r_b;
                n_state     = ST_ADD_B;
            end

            ST_ADD_B: begin
                w_adj_we    = 1'b1;
                w_adj_waddr = r_b;
                w_adj_wdata = r_row_q | (ONE_BIT << r_a);
                n_state     = ST_IDLE;
            end

            // Sweep rows below the count: drop column a, and in row a drop all in use
            ST_DEL: begin
                if (r_wpend) begin
                    w_adj_we    = 1'b1;
                    w_adj_waddr = r_widx;
                    w_adj_wdata = r_row_q & ~(ONE_BIT << r_a) &
                                  ((r_widx == r_a) ? ~r_nmask : '1);
                end
                if (EW'(r_idx) < r_n) begin
                    w_adj_re    = 1'b1;
                    w_adj_raddr = w_idx_m[VW-1:0];
                    n_widx      = w_idx_m[VW-1:0];
                    n_wpend     = 1'b1;
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            // Descend to the lowest unvisited neighbor of the top, pop, or finish at the root
            ST_DFS_EVAL: begin
                if (w_found) begin
                    if (w_emit_rdy) begin
                        s_emit.push = 1'b1;
                        n_visited   = r_visited | (ONE_BIT << w_ffs_idx);
                        w_lst_we    = 1'b1;
                        w_lst_waddr = r_depth[VW-1:0];
                        w_lst_wdata = w_ffs_idx;
                        n_depth     = r_depth + CW'(1);
                        w_adj_re    = 1'b1;
                        w_adj_raddr = w_ffs_idx;
                    end
                end else if (r_depth == CW'(1)) begin
                    if (w_emit_rdy) begin
                        s_emit.flush = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    w_lst_re    = 1'b1;
                    w_lst_raddr = w_pop_pos[VW-1:0];
                    n_depth     = r_depth - CW'(1);
                    n_state     = ST_DFS_POP;
                end
            end

            // New top is out of the stack memory: fetch its row
            ST_DFS_POP: begin
                w_adj_re    = 1'b1;
                w_adj_raddr = r_lst_q;
                n_state     = ST_DFS_EVAL;
            end

            ST_BFS_DEQ: begin
                if (r_head == r_tail) begin
                    if (w_emit_rdy) begin
                        s_emit.flush = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    w_lst_re    = 1'b1;
                    w_lst_raddr = r_head[VW-1:0];
                    n_head      = r_head + CW'(1);
                    n_state     = ST_BFS_QRD;
                end
            end

            ST_BFS_QRD: begin
                w_adj_re    = 1'b1;
                w_adj_raddr = r_lst_q;
                n_state     = ST_BFS_SCAN;
            end

            // Enqueue neighbors in rising order, one per cycle while the result stage is ready
            ST_BFS_SCAN: begin
                if (w_found) begin
                    if (w_emit_rdy) begin
                        s_emit.push = 1'b1;
                        n_visited   = r_visited | (ONE_BIT << w_ffs_idx);
                        w_lst_we    = 1'b1;
                        w_lst_waddr = r_tail[VW-1:0];
                        w_lst_wdata = w_ffs_idx;
                        n_tail      = r_tail + CW'(1);
                    end
                end else begin
                    n_state = ST_BFS_DEQ;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_vertex_count <= amgt_pkg::VERTEX_COUNT_RST;
            r_visited      <= '0;
            r_depth        <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_idx          <= '0;
            r_wpend        <= 1'b0;
            r_row_vld      <= '0;
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_depth   <= n_depth;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_idx     <= n_idx;
            r_wpend   <= n_wpend;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end
            if (w_adj_we) begin
                r_row_vld[w_adj_waddr] <= 1'b1;
            end
        end
    end

    // Request operands
    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_n     <= n_n;
        r_nmask <= n_nmask;
        r_widx  <= n_widx;
    end

    // Adjacency memory; a row never written reads as empty
    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            r_adj_mem[w_adj_waddr] <= w_adj_wdata;
        end
        if (w_adj_re) begin
            r_row_q <= r_row_vld[w_adj_raddr] ? r_adj_mem[w_adj_raddr] : '0;
        end
    end

    // Stack / queue memory
    always_ff @(posedge i_clk) begin
        if (w_lst_we) begin
            r_lst_mem[w_lst_waddr] <= w_lst_wdata;
        end
        if (w_lst_re) begin
            r_lst_q <= r_lst_mem[w_lst_raddr];
        end
    end

    amgt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (s_emit),
        .o_ready     (w_emit_rdy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_vertex    (o_vertex),
        .o_last      (o_last)
    );

    // Stack never grows past the vertex limit
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(MAX_VERTICES))
        else $error("stack depth above vertex limit");

    // Queue head never passes the tail
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head past tail");

    // Matrix is only written by edit requests
    a_adj_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adj_we |-> (r_state == ST_ADD_A || r_state == ST_ADD_B || r_state == ST_DEL))
        else $error("adjacency write outside edit states");

    // A traversal starts with only its start vertex marked
    a_start_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> $onehot(r_visited))
        else $error("visited marks not reset at traversal start");

endmodule
